// ----- rtl/tocs_pkg.sv -----
// shared types and constants for the three-operand cpu step block
// no dependencies; used by the interfaces, the alu and the top level
`default_nettype none

package tocs_pkg;

  localparam int unsigned DMEM_WORDS_DEF   = 4096;
  localparam int unsigned IMEM_WORDS_DEF   = 4096;
  localparam int unsigned IO_REG_COUNT_DEF = 23;

  localparam int unsigned INSTR_W = 48;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned PC_W    = 13;
  localparam int unsigned PCO_W   = 12;
  localparam int unsigned IOA_W   = 5;

  // io register map
  localparam int unsigned IO_EN0     = 0;
  localparam int unsigned IO_EN1     = 1;
  localparam int unsigned IO_EN2     = 2;
  localparam int unsigned IO_ST0     = 3;
  localparam int unsigned IO_ST1     = 4;
  localparam int unsigned IO_ST2     = 5;
  localparam int unsigned IO_HANDLER = 6;
  localparam int unsigned IO_RETURN  = 7;
  localparam int unsigned IO_CLOCK   = 8;
  localparam int unsigned IO_TMR_EN  = 11;
  localparam int unsigned IO_TMR_CUR = 12;
  localparam int unsigned IO_TMR_MAX = 13;
  localparam int unsigned IO_MON_CMD = 22;

  typedef enum logic [7:0] {
    OP_ADD  = 8'd0,
    OP_SUB  = 8'd1,
    OP_MAC  = 8'd2,
    OP_AND  = 8'd3,
    OP_OR   = 8'd4,
    OP_XOR  = 8'd5,
    OP_SLL  = 8'd6,
    OP_SRA  = 8'd7,
    OP_SRL  = 8'd8,
    OP_BEQ  = 8'd9,
    OP_BNE  = 8'd10,
    OP_BLT  = 8'd11,
    OP_BGT  = 8'd12,
    OP_BLE  = 8'd13,
    OP_BGE  = 8'd14,
    OP_JAL  = 8'd15,
    OP_LW   = 8'd16,
    OP_SW   = 8'd17,
    OP_RETI = 8'd18,
    OP_IN   = 8'd19,
    OP_OUT  = 8'd20,
    OP_HALT = 8'd21
  } op_e;

  // alu verdict handed to the top level
  typedef struct packed {
    logic              wr_en;
    logic [DATA_W-1:0] wr_data;
    logic              is_branch;
    logic              take;
  } alu_res_t;

  function automatic logic [DATA_W-1:0] sext12(input logic [11:0] v);
    sext12 = {{(DATA_W-12){v[11]}}, v};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tocs_in_if.sv -----
// input channel: instruction word and interrupt pulses
// depends on tocs_pkg
`default_nettype none

interface tocs_in_if;
  import tocs_pkg::*;
  logic               valid;
  logic               ready;
  logic [INSTR_W-1:0] instr_word;
  logic               irq1_event;
  logic               irq2_event;
  modport source (output valid, output instr_word, output irq1_event, output irq2_event,
                  input ready);
  modport sink (input valid, input instr_word, input irq1_event, input irq2_event,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/tocs_out_if.sv -----
// result channel: next pc, halt and io write report
// depends on tocs_pkg
`default_nettype none

interface tocs_out_if;
  import tocs_pkg::*;
  logic              valid;
  logic              ready;
  logic [PCO_W-1:0]  next_pc;
  logic              halt_flag;
  logic              io_write_valid;
  logic [IOA_W-1:0]  io_write_addr;
  logic [DATA_W-1:0] io_write_data;
  modport source (output valid, output next_pc, output halt_flag, output io_write_valid,
                  output io_write_addr, output io_write_data, input ready);
  modport sink (input valid, input next_pc, input halt_flag, input io_write_valid,
                input io_write_addr, input io_write_data, output ready);
endinterface

`default_nettype wire

// ----- rtl/tocs_alu.sv -----
// arithmetic, logic, shift and branch compare for one instruction
// depends on tocs_pkg
`default_nettype none

module tocs_alu (
  input  logic [7:0]                 op_i,
  input  logic [tocs_pkg::DATA_W-1:0] a_i,
  input  logic [tocs_pkg::DATA_W-1:0] b_i,
  input  logic [tocs_pkg::DATA_W-1:0] c_i,
  output tocs_pkg::alu_res_t          res_o
);
  import tocs_pkg::*;

  logic [DATA_W-1:0] prod;
  logic              lt_ab, lt_ba;

  assign prod  = a_i * b_i;
  assign lt_ab = $signed(a_i) < $signed(b_i);
  assign lt_ba = $signed(b_i) < $signed(a_i);

  always_comb begin
    res_o = '0;
    unique case (op_i)
      OP_ADD: begin res_o.wr_en = 1'b1; res_o.wr_data = a_i + b_i + c_i; end
      OP_SUB: begin res_o.wr_en = 1'b1; res_o.wr_data = a_i - b_i - c_i; end
      OP_MAC: begin res_o.wr_en = 1'b1; res_o.wr_data = prod + c_i; end
      OP_AND: begin res_o.wr_en = 1'b1; res_o.wr_data = a_i & b_i & c_i; end
      OP_OR:  begin res_o.wr_en = 1'b1; res_o.wr_data = a_i | b_i | c_i; end
      OP_XOR: begin res_o.wr_en = 1'b1; res_o.wr_data = a_i ^ b_i ^ c_i; end
      OP_SLL: begin res_o.wr_en = 1'b1; res_o.wr_data = a_i << b_i[4:0]; end
      OP_SRA: begin
        res_o.wr_en   = 1'b1;
        res_o.wr_data = DATA_W'($signed(a_i) >>> b_i[4:0]);
      end
      OP_SRL: begin res_o.wr_en = 1'b1; res_o.wr_data = a_i >> b_i[4:0]; end
      OP_BEQ: begin res_o.is_branch = 1'b1; res_o.take = (a_i == b_i); end
      OP_BNE: begin res_o.is_branch = 1'b1; res_o.take = (a_i != b_i); end
      OP_BLT: begin res_o.is_branch = 1'b1; res_o.take = lt_ab; end
      OP_BGT: begin res_o.is_branch = 1'b1; res_o.take = lt_ba; end
      OP_BLE: begin res_o.is_branch = 1'b1; res_o.take = !lt_ba; end
      OP_BGE: begin res_o.is_branch = 1'b1; res_o.take = !lt_ab; end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/three_operand_cpu_step.sv -----
// top level of the three-operand cpu step: decode, register file, data memory,
// io registers, timer and interrupt entry; depends on tocs_pkg, the two
// channel interfaces and tocs_alu
//
// usage
//   in_i  (sink)  : one transaction per instruction: the 48-bit word fetched at
//                   the pc reported last, plus the irq1/irq2 pulses of that cycle
//   out_o (source): one transaction per instruction: next pc, halt flag and the
//                   io register write done by an out instruction (zero if none)
// execution: an instruction is registered in the execute register on acceptance
//   and executed from there into the result register, which offers its result
// throughput: one instruction per cycle while out_o.ready stays high; the data memory
//   has one port with a registered read, a load lands in the register file in the
//   cycle after it executes and is forwarded to the following instruction meanwhile
// reset: register file, io registers, pc, handler flag, halt state and cycle
//   count clear at once; the data memory is then zeroed one word a cycle, with
//   in_i.ready low, before the first transaction
// stall: when out_o.ready is low the result register holds, the execute
//   register holds its instruction, and in_i.ready falls only once both are full
`default_nettype none

module three_operand_cpu_step #(
  parameter int unsigned DMEM_WORDS   = tocs_pkg::DMEM_WORDS_DEF,
  parameter int unsigned IMEM_WORDS   = tocs_pkg::IMEM_WORDS_DEF,
  parameter int unsigned IO_REG_COUNT = tocs_pkg::IO_REG_COUNT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tocs_in_if.sink    in_i,
  tocs_out_if.source out_o
);
  import tocs_pkg::*;

  localparam int unsigned DmAw = $clog2(DMEM_WORDS);
  localparam int unsigned IoAw = $clog2(IO_REG_COUNT);

  // execute register
  logic               x_vld_q;
  logic [INSTR_W-1:0] x_instr_q;
  logic               x_irq1_q, x_irq2_q;
  logic               x_go;

  // output register
  logic              o_vld_q;
  logic [PCO_W-1:0]  o_pc_q;
  logic              o_halt_q;
  logic              o_wv_q;
  logic [IOA_W-1:0]  o_wa_q;
  logic [DATA_W-1:0] o_wd_q;

  // architectural state
  logic [DATA_W-1:0] rf_q [16];
  logic [DATA_W-1:0] io_q [IO_REG_COUNT];
  logic [DATA_W-1:0] io_d [IO_REG_COUNT];
  logic [PC_W-1:0]   pc_q, pc_d;
  logic              hnd_q, hnd_d;
  logic              stop_q, stop_d;
  logic [DATA_W-1:0] cyc_q;

  // data memory and pending load write
  logic [DATA_W-1:0] dmem [DMEM_WORDS];
  logic [DATA_W-1:0] rdata_q;
  logic              rd_ok_q;
  logic              pend_q;
  logic [3:0]        pend_rd_q;
  logic [DATA_W-1:0] pend_c_q;
  logic [DATA_W-1:0] fwd;

  // zeroing pass after reset
  logic              clr_q;
  logic [DmAw-1:0]   clr_addr_q;

  // decode
  logic [7:0]        op;
  logic [3:0]        rd, rs, rt, rm;
  logic [DATA_W-1:0] imm1, imm2;
  logic [DATA_W-1:0] a, b, c, dv;
  logic [DATA_W-1:0] sum_ab;
  logic [11:0]       maddr;
  logic              maddr_ok, ioa_ok;
  logic [IoAw-1:0]   ioa;
  logic              exec;
  alu_res_t          alu;

  logic              rf_we;
  logic [DATA_W-1:0] rf_wd;
  logic              mem_we, mem_re;
  logic              wv;
  logic              irq_any;

  assign x_go       = x_vld_q && (!o_vld_q || out_o.ready);
  assign in_i.ready = !clr_q && (!x_vld_q || x_go);

  assign op   = x_instr_q[47:40];
  assign rd   = x_instr_q[39:36];
  assign rs   = x_instr_q[35:32];
  assign rt   = x_instr_q[31:28];
  assign rm   = x_instr_q[27:24];
  assign imm1 = sext12(x_instr_q[23:12]);
  assign imm2 = sext12(x_instr_q[11:0]);

  // load result still in flight from the previous instruction
  assign fwd = (rd_ok_q ? rdata_q : '0) + pend_c_q;

  // operand read: R1/R2 take the immediates, a pending load is forwarded
  function automatic logic [DATA_W-1:0] opnd(
    input logic [3:0]        idx,
    input logic [DATA_W-1:0] i1,
    input logic [DATA_W-1:0] i2,
    input logic              pv,
    input logic [3:0]        prd,
    input logic [DATA_W-1:0] fv,
    input logic [DATA_W-1:0] rv
  );
    if (idx == 4'd1)                 opnd = i1;
    else if (idx == 4'd2)            opnd = i2;
    else if (pv && idx == prd)       opnd = fv;
    else                             opnd = rv;
  endfunction

  assign a  = opnd(rs, imm1, imm2, pend_q, pend_rd_q, fwd, rf_q[rs]);
  assign b  = opnd(rt, imm1, imm2, pend_q, pend_rd_q, fwd, rf_q[rt]);
  assign c  = opnd(rm, imm1, imm2, pend_q, pend_rd_q, fwd, rf_q[rm]);
  assign dv = opnd(rd, imm1, imm2, pend_q, pend_rd_q, fwd, rf_q[rd]);

  assign sum_ab   = a + b;
  assign maddr    = sum_ab[11:0];
  assign maddr_ok = 32'(maddr) < DMEM_WORDS;
  assign ioa_ok   = sum_ab < 32'(IO_REG_COUNT);
  assign ioa      = sum_ab[IoAw-1:0];

  // instruction runs only if the core is alive and pc is inside memory
  assign exec = !stop_q && (32'(pc_q) < IMEM_WORDS);

  tocs_alu u_alu (
    .op_i  (op),
    .a_i   (a),
    .b_i   (b),
    .c_i   (c),
    .res_o (alu)
  );

  // next architectural state of one step
  always_comb begin
    io_d   = io_q;
    pc_d   = pc_q;
    hnd_d  = hnd_q;
    stop_d = stop_q;
    rf_we  = 1'b0;
    rf_wd  = alu.wr_data;
    mem_we = 1'b0;
    mem_re = 1'b0;
    wv     = 1'b0;

    io_d[IoAw'(IO_CLOCK)] = cyc_q;

    if (!exec) begin
      stop_d = 1'b1;
    end else begin
      pc_d = pc_q + 1'b1;
      if (alu.wr_en) begin
        rf_we = 1'b1;
      end else if (alu.is_branch) begin
        pc_d = alu.take ? {1'b0, c[11:0]} : pc_q + 1'b1;
      end else begin
        unique case (op)
          OP_JAL: begin
            rf_we = 1'b1;
            rf_wd = DATA_W'(pc_q) + 1'b1;
            pc_d  = {1'b0, c[11:0]};
          end
          OP_LW:   mem_re = 1'b1;
          OP_SW:   mem_we = maddr_ok;
          OP_RETI: begin
            pc_d  = {1'b0, io_q[IoAw'(IO_RETURN)][11:0]};
            hnd_d = 1'b0;
          end
          OP_IN: begin
            rf_we = ioa_ok;
            rf_wd = io_d[ioa];
          end
          OP_OUT: begin
            if (ioa_ok) begin
              wv        = 1'b1;
              io_d[ioa] = c;
              if (32'(ioa) == IO_MON_CMD && c == 32'd1) io_d[IoAw'(IO_MON_CMD)] = '0;
            end
          end
          OP_HALT: begin
            stop_d = 1'b1;
            pc_d   = pc_q;
          end
          default: ;
        endcase
      end
    end

    if (x_irq2_q) io_d[IoAw'(IO_ST2)] = 32'd1;

    // timer tick
    if (io_d[IoAw'(IO_TMR_EN)] == 32'd1) begin
      io_d[IoAw'(IO_TMR_CUR)] = io_d[IoAw'(IO_TMR_CUR)] + 1'b1;
      if (io_d[IoAw'(IO_TMR_CUR)] == io_d[IoAw'(IO_TMR_MAX)]) begin
        io_d[IoAw'(IO_TMR_CUR)] = '0;
        io_d[IoAw'(IO_ST0)]     = 32'd1;
      end
    end

    if (x_irq1_q) io_d[IoAw'(IO_ST1)] = 32'd1;

    irq_any = ((io_d[IoAw'(IO_EN0)] & io_d[IoAw'(IO_ST0)]) |
               (io_d[IoAw'(IO_EN1)] & io_d[IoAw'(IO_ST1)]) |
               (io_d[IoAw'(IO_EN2)] & io_d[IoAw'(IO_ST2)])) != '0;
    if (irq_any && !hnd_d) begin
      io_d[IoAw'(IO_RETURN)] = DATA_W'(pc_d);
      pc_d  = {1'b0, io_d[IoAw'(IO_HANDLER)][11:0]};
      hnd_d = 1'b1;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      x_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      x_instr_q <= in_i.instr_word;
      x_irq1_q  <= in_i.irq1_event;
      x_irq2_q  <= in_i.irq2_event;
    end
  end

  // architectural state; a stopped core changes nothing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_q   <= '{default: '0};
      io_q   <= '{default: '0};
      pc_q   <= '0;
      hnd_q  <= 1'b0;
      stop_q <= 1'b0;
      cyc_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      if (pend_q) rf_q[pend_rd_q] <= fwd;
      pend_q <= 1'b0;
      if (x_go && !stop_q) begin
        io_q   <= io_d;
        pc_q   <= pc_d;
        hnd_q  <= hnd_d;
        stop_q <= stop_d;
        cyc_q  <= cyc_q + 1'b1;
        if (exec) begin
          rf_q[1] <= imm1;
          rf_q[2] <= imm2;
          if (rf_we && rd > 4'd2) rf_q[rd] <= rf_wd;
          pend_q <= mem_re && rd > 4'd2;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (x_go && mem_re) begin
      pend_rd_q <= rd;
      pend_c_q  <= c;
      rd_ok_q   <= maddr_ok;
    end
  end

  // zeroing pass: one data memory word per cycle after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == DmAw'(DMEM_WORDS - 1)) clr_q <= 1'b0;
    end
  end

  // single port data memory with registered read
  always_ff @(posedge clk_i) begin
    if (clr_q) dmem[clr_addr_q] <= '0;
    else if (x_go && mem_we) dmem[maddr[DmAw-1:0]] <= c + dv;
    if (x_go && mem_re) rdata_q <= dmem[maddr[DmAw-1:0]];
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else if (x_go) begin
      o_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      o_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (x_go) begin
      o_pc_q   <= stop_q ? pc_q[PCO_W-1:0] : pc_d[PCO_W-1:0];
      o_halt_q <= stop_q || stop_d;
      o_wv_q   <= !stop_q && wv;
      o_wa_q   <= (!stop_q && wv) ? IOA_W'(ioa) : '0;
      o_wd_q   <= (!stop_q && wv) ? c : '0;
    end
  end

  assign out_o.valid          = o_vld_q;
  assign out_o.next_pc        = o_pc_q;
  assign out_o.halt_flag      = o_halt_q;
  assign out_o.io_write_valid = o_wv_q;
  assign out_o.io_write_addr  = o_wa_q;
  assign out_o.io_write_data  = o_wd_q;

  // a halted core stays halted
  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q |=> stop_q)
    else $error("halt state cleared");

  // a load write is pending only in the cycle after a load executes
  a_pend_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> $past(x_go && mem_re))
    else $error("pending load without a load");

  // r0 never changes
  a_r0_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_q[0] == '0)
    else $error("r0 written");

  // a reported io write always comes with a live core result
  a_wv_alive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    x_go && stop_q |=> !o_wv_q && o_halt_q)
    else $error("io write from a halted core");

endmodule

`default_nettype wire
